// ----- hw/rtl/plus_shape_erosion_count_top_macros.svh -----
// Assertion macros shared by the plus-shape erosion counter RTL.
`ifndef PLUS_SHAPE_EROSION_COUNT_TOP_MACROS_SVH
`define PLUS_SHAPE_EROSION_COUNT_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PECNT_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PECNT_ASSERT_SAME(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pecnt_pkg.sv -----
// Shared types and constants of the plus-shape erosion counter.
package pecnt_pkg;

  localparam int FrameWidthBits  = 7;
  localparam int FrameHeightBits = 11;
  localparam int RowBits         = 10;
  localparam int MaxHeight       = 1024;
  localparam int CountBits       = 16;
  localparam int CfgIndexBits    = 1;
  localparam int CfgDataBits     = 11;

  // Line store: four row slots, each entry keeps a 3-pixel horizontal window.
  localparam int StoreRows = 4;
  localparam int SlotBits  = 2;
  localparam int WinBits   = 3;
  localparam int WordBits  = StoreRows * WinBits;

  typedef logic [CfgIndexBits-1:0] cfg_index_t;
  localparam cfg_index_t CFG_FRAME_WIDTH  = 1'b0;
  localparam cfg_index_t CFG_FRAME_HEIGHT = 1'b1;

  // Per-pixel control handed from the scan stage to the judge stage.
  typedef struct packed {
    logic                eligible;  // open pixel whose centre may count
    logic                last;      // last pixel of the frame
    logic [SlotBits-1:0] slot;      // line store slot of the current row
  } scan_req_t;

endpackage

// ----- hw/rtl/plus_shape_erosion_count_top.sv -----
// Top level of the radius-2 plus-shape erosion counter.
// Throughput: one pixel per cycle unless stalled; store does one write and two reads per pixel.
// Stall: a frame's last pixel waits in the judge stage while the previous count is unread.
// The frame's last pixel is registered in the judge stage, then its count in the output register.
// Reset clears positions, tally and valid flags; width and height return to 64.
// The line store is not cleared: rows are always written before a centre reads them.
module plus_shape_erosion_count_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes (frame width, frame height)
  input  logic                               cfg_write,
  input  pecnt_pkg::cfg_index_t              cfg_index,
  input  logic [pecnt_pkg::CfgDataBits-1:0]  cfg_data,
  // pixel request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               pixel,
  // count result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pecnt_pkg::CountBits-1:0]    cross_count
);

  localparam int ColBits = $clog2(MAX_WIDTH);

  pecnt_pkg::scan_req_t             req;
  logic                             accept;
  logic [ColBits-1:0]               addr_c;
  logic [ColBits-1:0]               addr_ahead;
  logic [pecnt_pkg::WinBits-1:0]    wr_win;
  logic [pecnt_pkg::WordBits-1:0]   word_c;
  logic [pecnt_pkg::WordBits-1:0]   word_ahead;

  // A request moves on every edge where the judge stage can take it.
  assign accept = in_valid && in_ready;

  // Scan stage: raster position, config registers, and the window of the
  // current row that goes into the line store next to the pixel itself.
  pecnt_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel      (pixel),
    .req        (req),
    .addr_c     (addr_c),
    .addr_ahead (addr_ahead),
    .wr_win     (wr_win)
  );

  // Line store: column c gives the vertical arm and the left half of the
  // middle row; column c+2 gives the right half of the middle row.
  pecnt_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk        (clk),
    .accept     (accept),
    .addr_c     (addr_c),
    .addr_ahead (addr_ahead),
    .wr_slot    (req.slot),
    .wr_win     (wr_win),
    .word_c     (word_c),
    .word_ahead (word_ahead)
  );

  // Judge stage: check the full plus, advance the tally, and drop the frame
  // count into the output register; the register lets the next frame start
  // while the count waits to be read.
  pecnt_judge u_judge (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .word_c      (word_c),
    .word_ahead  (word_ahead),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cross_count (cross_count)
  );

endmodule

// ----- hw/rtl/pecnt_line_store.sv -----
// Four-row line store with one masked write port and two registered read ports.
module pecnt_line_store #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]        addr_c,
  input  logic [$clog2(MAX_WIDTH)-1:0]        addr_ahead,
  input  logic [pecnt_pkg::SlotBits-1:0]      wr_slot,
  input  logic [pecnt_pkg::WinBits-1:0]       wr_win,
  output logic [pecnt_pkg::WordBits-1:0]      word_c,
  output logic [pecnt_pkg::WordBits-1:0]      word_ahead
);

  logic [pecnt_pkg::WordBits-1:0] mem [MAX_WIDTH];

  // Read old contents and write the current row's window on the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_c     <= mem[addr_c];
      word_ahead <= mem[addr_ahead];
      mem[addr_c][wr_slot*pecnt_pkg::WinBits +: pecnt_pkg::WinBits] <= wr_win;
    end
  end

endmodule

// ----- hw/rtl/pecnt_scan.sv -----
// Raster position tracking, configuration registers and per-pixel eligibility.
module pecnt_scan #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  pecnt_pkg::cfg_index_t                cfg_index,
  input  logic [pecnt_pkg::CfgDataBits-1:0]    cfg_data,
  input  logic                                 accept,
  input  logic                                 pixel,
  output pecnt_pkg::scan_req_t                 req,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_c,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_ahead,
  output logic [pecnt_pkg::WinBits-1:0]        wr_win
);

  localparam int ColBits = $clog2(MAX_WIDTH);
  localparam int WBase   = $clog2(MAX_WIDTH + 2);
  localparam int CmpBits = (WBase > pecnt_pkg::FrameWidthBits) ? WBase
                                                               : pecnt_pkg::FrameWidthBits;
  localparam logic [CmpBits-1:0] MaxW = CmpBits'(MAX_WIDTH);
  localparam logic [pecnt_pkg::FrameHeightBits-1:0] MaxH =
    pecnt_pkg::FrameHeightBits'(pecnt_pkg::MaxHeight);

  logic [pecnt_pkg::FrameWidthBits-1:0]  frame_width;
  logic [pecnt_pkg::FrameHeightBits-1:0] frame_height;
  logic [ColBits-1:0]                    col;
  logic [pecnt_pkg::RowBits-1:0]         row;
  logic                                  prev1;
  logic                                  prev2;

  logic [CmpBits-1:0]                    width_eff;
  logic [CmpBits-1:0]                    col_ext;
  logic [CmpBits-1:0]                    ahead_ext;
  logic [pecnt_pkg::FrameHeightBits-1:0] height_eff;
  logic [pecnt_pkg::FrameHeightBits-1:0] row_inc;
  logic                                  last_col;
  logic                                  last_row;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = CmpBits'(1);
    end else if (CmpBits'(frame_width) > MaxW) begin
      width_eff = MaxW;
    end else begin
      width_eff = CmpBits'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = pecnt_pkg::FrameHeightBits'(1);
    end else if (frame_height > MaxH) begin
      height_eff = MaxH;
    end else begin
      height_eff = frame_height;
    end
  end

  assign col_ext   = CmpBits'(col);
  assign ahead_ext = col_ext + CmpBits'(2);
  assign row_inc   = pecnt_pkg::FrameHeightBits'(row) + pecnt_pkg::FrameHeightBits'(1);
  assign last_col  = (col_ext + CmpBits'(1)) >= width_eff;
  assign last_row  = row_inc >= height_eff;

  // Centre two rows up may count only away from every edge.
  assign req.eligible = pixel && (row[pecnt_pkg::RowBits-1:2] != '0) &&
                        (col_ext >= CmpBits'(2)) && (ahead_ext < width_eff);
  assign req.last     = last_col && last_row;
  assign req.slot     = row[pecnt_pkg::SlotBits-1:0];

  assign addr_c     = col;
  assign addr_ahead = (ahead_ext < MaxW) ? ahead_ext[ColBits-1:0] : col;
  assign wr_win     = {prev2, prev1, pixel};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= pecnt_pkg::FrameWidthBits'(64);
      frame_height <= pecnt_pkg::FrameHeightBits'(64);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pecnt_pkg::CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data[pecnt_pkg::FrameWidthBits-1:0];
        end
        pecnt_pkg::CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      prev1 <= 1'b0;
      prev2 <= 1'b0;
    end else if (accept) begin
      prev1 <= pixel;
      prev2 <= prev1;
      if (last_col && last_row) begin
        col <= '0;
        row <= '0;
      end else if (last_col) begin
        col <= '0;
        row <= row_inc[pecnt_pkg::RowBits-1:0];
      end else begin
        col <= col + ColBits'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/pecnt_judge.sv -----
// Plus-shape check, saturating tally and result register.
`include "plus_shape_erosion_count_top_macros.svh"

module pecnt_judge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  pecnt_pkg::scan_req_t               req,
  input  logic [pecnt_pkg::WordBits-1:0]     word_c,
  input  logic [pecnt_pkg::WordBits-1:0]     word_ahead,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pecnt_pkg::CountBits-1:0]    cross_count
);

  function automatic logic [pecnt_pkg::WinBits-1:0] slot_field(
    input logic [pecnt_pkg::WordBits-1:0] word,
    input logic [pecnt_pkg::SlotBits-1:0] slot
  );
    slot_field = word[slot*pecnt_pkg::WinBits +: pecnt_pkg::WinBits];
  endfunction

  // Pixel at the window's own column for one row slot.
  function automatic logic slot_pixel(
    input logic [pecnt_pkg::WordBits-1:0] word,
    input logic [pecnt_pkg::SlotBits-1:0] slot
  );
    slot_pixel = word[slot*pecnt_pkg::WinBits];
  endfunction

  pecnt_pkg::scan_req_t              s1_req;
  logic                              s1_valid;
  logic [pecnt_pkg::CountBits-1:0]   tally;

  logic                              s1_adv;
  logic                              s1_fire;
  logic                              end_fire;
  logic                              end_blocked;
  logic                              mid_fire;
  logic [pecnt_pkg::SlotBits-1:0]    slot_m3;
  logic [pecnt_pkg::SlotBits-1:0]    slot_m2;
  logic [pecnt_pkg::SlotBits-1:0]    slot_m1;
  logic [pecnt_pkg::WinBits-1:0]     mid_left;
  logic [pecnt_pkg::WinBits-1:0]     mid_right;
  logic                              full;
  logic [pecnt_pkg::CountBits-1:0]   tally_next;

  // Slots relative to the current row: the current slot still holds row r-4.
  assign slot_m3 = s1_req.slot + pecnt_pkg::SlotBits'(1);
  assign slot_m2 = s1_req.slot + pecnt_pkg::SlotBits'(2);
  assign slot_m1 = s1_req.slot + pecnt_pkg::SlotBits'(3);

  assign mid_left  = slot_field(word_c, slot_m2);
  assign mid_right = slot_field(word_ahead, slot_m2);

  assign full = s1_req.eligible &&
                slot_pixel(word_c, s1_req.slot) &&
                slot_pixel(word_c, slot_m3) &&
                slot_pixel(word_c, slot_m1) &&
                (&mid_left) && (&mid_right[1:0]);

  assign tally_next = (full && (tally != '1)) ? tally + pecnt_pkg::CountBits'(1) : tally;

  // Hold the frame-end pixel while the previous result is still unread.
  assign s1_adv   = !s1_req.last || !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  assign end_fire    = s1_fire && s1_req.last;
  assign end_blocked = s1_valid && s1_req.last && out_valid && !out_ready;
  assign mid_fire    = s1_fire && !s1_req.last;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (s1_fire) begin
      tally <= s1_req.last ? '0 : tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_req.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_req.last) begin
      cross_count <= tally_next;
    end
  end

  `PECNT_ASSERT_NEXT(a_frame_end_clears_tally, clk, rst, end_fire, tally == '0, "tally kept")
  `PECNT_ASSERT_NEXT(a_blocked_end_holds, clk, rst, end_blocked, s1_valid && s1_req.last, "end lost")
  `PECNT_ASSERT_NEXT(a_tally_no_decrease, clk, rst, mid_fire, tally >= $past(tally), "tally fell")
  `PECNT_ASSERT_SAME(a_blocked_end_stalls_input, clk, rst, end_blocked, !in_ready, "input taken")

endmodule
